[rtl/core/aup_pkg.sv]
package aup_pkg;

  localparam int StepW     = 5;
  localparam int SelW      = 3;
  localparam int NumCoefs  = 6;
  localparam int SampleW   = 16;
  localparam int WordW     = 32;
  localparam int CoefW     = 16;
  localparam int QShift    = 10;

  localparam logic signed [CoefW-1:0] CoefReset [NumCoefs] = '{
    16'sd1746, 16'sd14986, -16'sd26453, 16'sd6854, 16'sd25769, -16'sd9994
  };

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_MUL,
    OP_UPD,
    OP_FIN_EVEN,
    OP_FIN_ODD
  } op_e;

  // Branch kinds: fall through, hold until input transfer,
  // hold until output register is free then return home, return home.
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_IN,
    BR_OUT,
    BR_HOME
  } br_e;

  typedef struct packed {
    op_e             op;
    br_e             br;
    logic [SelW-1:0] sel;
    logic            add_y;
  } uword_t;

  typedef struct packed {
    op_e             op;
    logic [SelW-1:0] sel;
    logic            add_y;
    logic            fire;
  } ctrl_t;

  function automatic uword_t uw(op_e op, br_e br, logic [SelW-1:0] sel, logic add_y);
    uword_t w;
    w.op    = op;
    w.br    = br;
    w.sel   = sel;
    w.add_y = add_y;
    return w;
  endfunction

  // Microprogram: three steps per allpass section, even cascade on states 0..2,
  // odd cascade on states 3..5. Third section of each cascade adds y back.
  function automatic uword_t ucode(logic [StepW-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = uw(OP_LOAD,     BR_IN,   3'd0, 1'b0);
      5'd1:    w = uw(OP_DIFF,     BR_NEXT, 3'd0, 1'b0);
      5'd2:    w = uw(OP_MUL,      BR_NEXT, 3'd0, 1'b0);
      5'd3:    w = uw(OP_UPD,      BR_NEXT, 3'd0, 1'b0);
      5'd4:    w = uw(OP_DIFF,     BR_NEXT, 3'd1, 1'b0);
      5'd5:    w = uw(OP_MUL,      BR_NEXT, 3'd1, 1'b0);
      5'd6:    w = uw(OP_UPD,      BR_NEXT, 3'd1, 1'b0);
      5'd7:    w = uw(OP_DIFF,     BR_NEXT, 3'd2, 1'b0);
      5'd8:    w = uw(OP_MUL,      BR_NEXT, 3'd2, 1'b0);
      5'd9:    w = uw(OP_UPD,      BR_NEXT, 3'd2, 1'b1);
      5'd10:   w = uw(OP_FIN_EVEN, BR_NEXT, 3'd0, 1'b0);
      5'd11:   w = uw(OP_DIFF,     BR_NEXT, 3'd3, 1'b0);
      5'd12:   w = uw(OP_MUL,      BR_NEXT, 3'd3, 1'b0);
      5'd13:   w = uw(OP_UPD,      BR_NEXT, 3'd3, 1'b0);
      5'd14:   w = uw(OP_DIFF,     BR_NEXT, 3'd4, 1'b0);
      5'd15:   w = uw(OP_MUL,      BR_NEXT, 3'd4, 1'b0);
      5'd16:   w = uw(OP_UPD,      BR_NEXT, 3'd4, 1'b0);
      5'd17:   w = uw(OP_DIFF,     BR_NEXT, 3'd5, 1'b0);
      5'd18:   w = uw(OP_MUL,      BR_NEXT, 3'd5, 1'b0);
      5'd19:   w = uw(OP_UPD,      BR_NEXT, 3'd5, 1'b1);
      5'd20:   w = uw(OP_FIN_ODD,  BR_OUT,  3'd0, 1'b0);
      default: w = uw(OP_NOP,      BR_HOME, 3'd0, 1'b0);
    endcase
    return w;
  endfunction

  // Round, shift right by QShift, saturate to 16 bits.
  function automatic logic [SampleW-1:0] finish(logic [WordW-1:0] v);
    logic signed [WordW-QShift+1:0] r;
    logic signed [WordW-QShift+1:0] h;
    logic [SampleW-1:0]             res;
    r = $signed({v[WordW-1], v[WordW-1:QShift-1]}) +
        $signed({{(WordW-QShift+1){1'b0}}, 1'b1});
    h = r >>> 1;
    if (h > $signed({{(WordW-QShift-SampleW+3){1'b0}}, {(SampleW-1){1'b1}}})) begin
      res = {1'b0, {(SampleW-1){1'b1}}};
    end else if (h < $signed({{(WordW-QShift-SampleW+3){1'b1}}, {(SampleW-1){1'b0}}})) begin
      res = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      res = h[SampleW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/aup_sequencer.sv]
module aup_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output aup_pkg::ctrl_t       ctrl_o
);

  logic [aup_pkg::StepW-1:0] pc_q, pc_d;
  aup_pkg::uword_t           uw;
  logic                      fire;

  always_comb begin
    uw   = aup_pkg::ucode(pc_q);
    fire = 1'b1;
    pc_d = pc_q + aup_pkg::StepW'(1);
    case (uw.br)
      aup_pkg::BR_NEXT: begin
        fire = 1'b1;
        pc_d = pc_q + aup_pkg::StepW'(1);
      end
      aup_pkg::BR_IN: begin
        fire = in_valid_i;
        pc_d = in_valid_i ? pc_q + aup_pkg::StepW'(1) : pc_q;
      end
      aup_pkg::BR_OUT: begin
        fire = out_free_i;
        pc_d = out_free_i ? '0 : pc_q;
      end
      aup_pkg::BR_HOME: begin
        fire = 1'b0;
        pc_d = '0;
      end
      default: begin
        fire = 1'b0;
        pc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o   = (uw.br == aup_pkg::BR_IN);
  assign ctrl_o.op    = uw.op;
  assign ctrl_o.sel   = uw.sel;
  assign ctrl_o.add_y = uw.add_y;
  assign ctrl_o.fire  = fire;

endmodule

[rtl/core/aup_datapath.sv]
module aup_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aup_pkg::ctrl_t                    ctrl_i,
  input  logic signed [aup_pkg::SampleW-1:0] sample_in_i,
  input  logic                              last_sample_i,
  input  logic                              cfg_valid_i,
  input  logic [aup_pkg::SelW-1:0]          cfg_index_i,
  input  logic [aup_pkg::CoefW-1:0]         cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_free_o,
  output logic                              out_valid_o,
  output logic signed [aup_pkg::SampleW-1:0] even_sample_o,
  output logic signed [aup_pkg::SampleW-1:0] odd_sample_o,
  output logic                              last_pair_o
);

  localparam int WordW = aup_pkg::WordW;
  localparam int CoefW = aup_pkg::CoefW;
  localparam int ProdW = WordW + CoefW;

  logic signed [CoefW-1:0]  coef_q [aup_pkg::NumCoefs];
  logic [WordW-1:0]         st_q   [aup_pkg::NumCoefs];
  logic [WordW-1:0]         cur_q, in32_q, y_q, x_q;
  logic                     last_q;
  logic [aup_pkg::SampleW-1:0] even_q;
  logic                     out_valid_q;
  logic [aup_pkg::SampleW-1:0] out_even_q, out_odd_q;
  logic                     out_last_q;

  logic [WordW-1:0]         in32, st_rd, x_full;
  logic signed [ProdW-1:0]  prod;

  assign in32   = {{(WordW-aup_pkg::SampleW-aup_pkg::QShift){sample_in_i[aup_pkg::SampleW-1]}},
                   sample_in_i, {aup_pkg::QShift{1'b0}}};
  assign st_rd  = st_q[ctrl_i.sel];
  assign prod   = $signed(y_q) * coef_q[ctrl_i.sel];
  assign x_full = x_q + (ctrl_i.add_y ? y_q : '0);
  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aup_pkg::NumCoefs; i++) begin
        coef_q[i] <= aup_pkg::CoefReset[i];
      end
    end else if (cfg_valid_i && (cfg_index_i < aup_pkg::SelW'(aup_pkg::NumCoefs))) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < aup_pkg::NumCoefs; i++) begin
        st_q[i] <= '0;
      end
    end else if (ctrl_i.fire && ctrl_i.op == aup_pkg::OP_UPD) begin
      st_q[ctrl_i.sel] <= cur_q + x_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      case (ctrl_i.op)
        aup_pkg::OP_LOAD: begin
          cur_q  <= in32;
          in32_q <= in32;
          last_q <= last_sample_i;
        end
        aup_pkg::OP_DIFF: begin
          y_q <= cur_q - st_rd;
        end
        aup_pkg::OP_MUL: begin
          x_q <= prod[ProdW-1:CoefW];
        end
        aup_pkg::OP_UPD: begin
          cur_q <= st_rd + x_full;
        end
        aup_pkg::OP_FIN_EVEN: begin
          even_q <= aup_pkg::finish(cur_q);
          cur_q  <= in32_q;
        end
        aup_pkg::OP_FIN_ODD: begin
          out_even_q <= even_q;
          out_odd_q  <= aup_pkg::finish(cur_q);
          out_last_q <= last_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.fire && ctrl_i.op == aup_pkg::OP_FIN_ODD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign even_sample_o = out_even_q;
  assign odd_sample_o  = out_odd_q;
  assign last_pair_o   = out_last_q;

endmodule

[rtl/core/allpass_2x_upsampler.sv]
// 2x allpass upsampler. Each transferred input sample yields one output pair
// (even, odd). The microprogram runs 21 steps per sample: one load step,
// three steps per allpass section for six sections (difference, multiply,
// state update) and two rounding steps, all through a single shared 32x16
// multiplier. A new sample is taken only while the sequencer is at its first
// step, so a sample is not taken before the last one has been worked through;
// the result sits in an output register, and the next sample is taken and
// worked on while it waits. The sequencer holds at its last step while that
// register is still full and is not being read. Coefficients are written
// through the cfg port (index 0..5: even a, b, c, odd a, b, c); higher indexes
// are ignored. Write them only while the block is idle.
module allpass_2x_upsampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [aup_pkg::SampleW-1:0]  sample_in_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [aup_pkg::SampleW-1:0]  even_sample_o,
  output logic signed [aup_pkg::SampleW-1:0]  odd_sample_o,
  output logic                                last_pair_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aup_pkg::SelW-1:0]            cfg_index_i,
  input  logic [aup_pkg::CoefW-1:0]           cfg_data_i
);

  aup_pkg::ctrl_t ctrl;
  logic           out_free;

  assign cfg_ready_o = 1'b1;

  aup_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  aup_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .sample_in_i   (sample_in_i),
    .last_sample_i (last_sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .even_sample_o (even_sample_o),
    .odd_sample_o  (odd_sample_o),
    .last_pair_o   (last_pair_o)
  );

endmodule

[sim/allpass_2x_upsampler_tb.sv]
module allpass_2x_upsampler_tb;
  import aup_pkg::*;

  typedef enum logic [SelW-1:0] {
    REG_EVEN_A,
    REG_EVEN_B,
    REG_EVEN_C,
    REG_ODD_A,
    REG_ODD_B,
    REG_ODD_C,
    REG_SPARE6,
    REG_SPARE7
  } coef_reg_e;

  typedef struct {
    logic [SampleW-1:0] even;
    logic [SampleW-1:0] odd;
    logic               last;
  } pair_t;

  typedef struct {
    coef_reg_e        idx;
    logic [CoefW-1:0] data;
  } coef_write_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic                      last_sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [SampleW-1:0] even_sample_o;
  logic signed [SampleW-1:0] odd_sample_o;
  logic                      last_pair_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [SelW-1:0]           cfg_index_i;
  logic [CoefW-1:0]          cfg_data_i;

  // Shadow copy of the filter: coefficients and the six allpass state words.
  logic signed [CoefW-1:0] coef_m [NumCoefs];
  logic [WordW-1:0]        state_m [NumCoefs];

  pair_t       pending_pairs [$];
  coef_write_t pending_writes [$];

  int samples_sent = 0;
  int pairs_seen   = 0;
  int coef_writes  = 0;
  int fail_count   = 0;
  int hold_cycles  = 0;
  bit idle_en      = 1'b1;

  allpass_2x_upsampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_in_i   (sample_in_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .even_sample_o (even_sample_o),
    .odd_sample_o  (odd_sample_o),
    .last_pair_o   (last_pair_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 600000);
    $display("Some tests failed");
    $finish;
  end

  // One cascade of three allpass sections starting at state word base.
  function automatic logic [WordW-1:0] allpass_chain(input logic [WordW-1:0] in32,
                                                     input int base);
    logic [WordW-1:0] v, y, x, o;
    longint           prod;
    v = in32;
    for (int k = 0; k < 3; k++) begin
      y = v - state_m[base+k];
      prod = longint'($signed(y)) * longint'(coef_m[base+k]);
      x = prod[47:16];
      if (k == 2) x = x + y;
      o = state_m[base+k] + x;
      state_m[base+k] = v + x;
      v = o;
    end
    return v;
  endfunction

  function automatic logic [SampleW-1:0] round_sat(input logic [WordW-1:0] w);
    longint r;
    r = ((longint'($signed(w)) >>> (QShift - 1)) + 1) >>> 1;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[SampleW-1:0];
  endfunction

  function automatic pair_t upsample_pair(input logic [SampleW-1:0] s, input logic lst);
    pair_t            p;
    logic [WordW-1:0] in32;
    in32 = {{(WordW-SampleW-QShift){s[SampleW-1]}}, s, {QShift{1'b0}}};
    p.even = round_sat(allpass_chain(in32, 0));
    p.odd  = round_sat(allpass_chain(in32, 3));
    p.last = lst;
    return p;
  endfunction

  // Predict at every input transfer; track coefficient writes.
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) begin
      coef_writes++;
      if (cfg_index_i <= REG_ODD_C) coef_m[cfg_index_i] = cfg_data_i;
    end
    if (in_valid_i && in_ready_o) begin
      pending_pairs.push_back(upsample_pair(sample_in_i, last_sample_i));
    end
  end

  always @(posedge clk_i) begin
    pair_t want;
    if (out_valid_o && out_ready_i) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected pair even=%0d odd=%0d last=%0b", $time,
                 even_sample_o, odd_sample_o, last_pair_o);
      end else begin
        want = pending_pairs.pop_front();
        if (want.even !== even_sample_o) begin
          fail_count++;
          $display("%0t: even_sample expected %0d, got %0d", $time,
                   $signed(want.even), even_sample_o);
        end
        if (want.odd !== odd_sample_o) begin
          fail_count++;
          $display("%0t: odd_sample expected %0d, got %0d", $time,
                   $signed(want.odd), odd_sample_o);
        end
        if (want.last !== last_pair_o) begin
          fail_count++;
          $display("%0t: last_pair expected %0b, got %0b", $time, want.last, last_pair_o);
        end
      end
    end
  end

  // Receiver: random stall after each transfer while idle_en is set, plus a long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stall_left = idle_en ? $urandom_range(0, 10) : 0;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] s, input logic lst);
    int gap;
    gap = idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_in_i   <= s;
    last_sample_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  task automatic drain_pairs();
    in_valid_i <= 1'b0;
    while (pairs_seen < samples_sent) @(posedge clk_i);
  endtask

  task automatic queue_coef(input coef_reg_e idx, input logic [CoefW-1:0] val);
    coef_write_t w;
    w.idx  = idx;
    w.data = val;
    pending_writes.push_back(w);
  endtask

  // Back-to-back writes with valid held; only called once the block is idle.
  task automatic commit_coefs();
    foreach (pending_writes[i]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= pending_writes[i].idx;
      cfg_data_i  <= pending_writes[i].data;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    pending_writes.delete();
  endtask

  task automatic test_directed_samples();
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    repeat (3) send_sample(16'sh7FFF, 1'b0);
    repeat (3) send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    repeat (2) begin
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
    end
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    drain_pairs();
  endtask

  // Coefficient extremes; spare indexes must leave the filter alone.
  task automatic test_coef_extremes();
    logic [CoefW-1:0] even_v, odd_v;
    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0:       begin even_v = 16'h7FFF; odd_v = 16'h7FFF; end
        1:       begin even_v = 16'h8000; odd_v = 16'h8000; end
        2:       begin even_v = 16'h0000; odd_v = 16'h0000; end
        default: begin even_v = 16'h7FFF; odd_v = 16'h8000; end
      endcase
      queue_coef(REG_EVEN_A, even_v);
      queue_coef(REG_EVEN_B, even_v);
      queue_coef(REG_EVEN_C, even_v);
      queue_coef(REG_ODD_A, odd_v);
      queue_coef(REG_ODD_B, odd_v);
      queue_coef(REG_ODD_C, odd_v);
      queue_coef(REG_SPARE6, 16'hFFFF);
      queue_coef(REG_SPARE7, 16'h8001);
      commit_coefs();
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'($urandom), 1'b1);
      drain_pairs();
    end
    for (int r = REG_EVEN_A; r <= REG_ODD_C; r++) queue_coef(coef_reg_e'(r), CoefReset[r]);
    commit_coefs();
  endtask

  task automatic test_random_stream();
    logic [SampleW-1:0] s;
    logic [CoefW-1:0]   c;
    int                 period;
    for (int seg = 0; seg < 8; seg++) begin
      idle_en = (seg % 3 != 1);
      if (seg > 0) begin
        for (int r = REG_EVEN_A; r <= REG_SPARE7; r++) begin
          case ($urandom_range(0, 5))
            0:       c = 16'h7FFF;
            1:       c = 16'h8000;
            2:       c = 16'h0000;
            default: c = 16'($urandom);
          endcase
          if (r <= REG_ODD_C || $urandom_range(0, 3) == 0) queue_coef(coef_reg_e'(r), c);
        end
        commit_coefs();
      end
      period = $urandom_range(1, 12);
      for (int n = 0; n < 100; n++) begin
        if (seg == 5) begin
          // full-scale square wave drives the cascades into wrap and saturation
          s = ((n / period) % 2) ? 16'h8000 : 16'h7FFF;
        end else begin
          case ($urandom_range(0, 9))
            0:       s = 16'h7FFF;
            1:       s = 16'h8000;
            2, 3:    s = 16'($signed($urandom_range(0, 127)) - 64);
            default: s = 16'($urandom);
          endcase
        end
        send_sample(s, $urandom_range(0, 15) == 0);
      end
      drain_pairs();
    end
    idle_en = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering; the block must stall its input.
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_cycles = 400;
    repeat (16) send_sample(16'($urandom), $urandom_range(0, 1));
    idle_en = 1'b1;
    drain_pairs();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sample_in_i   = '0;
    last_sample_i = 1'b0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    foreach (coef_m[i]) begin
      coef_m[i]  = CoefReset[i];
      state_m[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_samples();
    test_coef_extremes();
    test_random_stream();
    test_backpressure();

    drain_pairs();
    repeat (30) @(posedge clk_i);
    if (pending_pairs.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected pairs never arrived", $time, pending_pairs.size());
    end
    $display("Covered %0d samples and %0d output pairs over %0d coefficient writes,",
             samples_sent, pairs_seen, coef_writes);
    $display("including saturation, coefficient extremes, spare indexes and a long stall.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[allpass_2x_upsampler.f]
rtl/core/aup_pkg.sv
rtl/core/aup_sequencer.sv
rtl/core/aup_datapath.sv
rtl/core/allpass_2x_upsampler.sv
sim/allpass_2x_upsampler_tb.sv
